// ===== rtl/core/mos6502_stream_disassembler_top_defines.svh =====
// Assertion macros for the stream disassembler checker.
// No dependencies; included by the checker file only.
`ifndef MOS6502_STREAM_DISASSEMBLER_TOP_DEFINES_SVH
`define MOS6502_STREAM_DISASSEMBLER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define M6502DIS_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("disassembler check failed");

// next-cycle implication, disabled in reset
`define M6502DIS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("disassembler check failed");

`endif

// ===== rtl/core/m6502dis_pkg.sv =====
// Types, code tables and decode functions for the 6502 stream disassembler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package m6502dis_pkg;

   typedef enum logic [5:0] {
      OP_ADC, OP_SBC, OP_ORA, OP_AND, OP_EOR, OP_STX, OP_STY, OP_STA,
      OP_LDX, OP_LDY, OP_LDA, OP_CMP, OP_ASL, OP_ROL, OP_LSR, OP_ROR,
      OP_DEC, OP_INC, OP_BIT, OP_JMP, OP_JMPI, OP_CPY, OP_CPX, OP_JSR,
      OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ,
      OP_PHP, OP_PLP, OP_PHA, OP_PLA, OP_DEY, OP_TAY, OP_INY, OP_INX,
      OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_TYA, OP_CLV, OP_CLD, OP_SED,
      OP_TXA, OP_TXS, OP_TAX, OP_TSX, OP_DEX, OP_NOP, OP_RTS, OP_BRK,
      OP_RTI
   } op_type;

   typedef enum logic [3:0] {
      MODE_IMM, MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL, MODE_ABS,
      MODE_IZX, MODE_IZY, MODE_ABX, MODE_ABY, MODE_IMP, MODE_ACC
   } mode_type;

   typedef enum logic [1:0] {
      PH_OPCODE, PH_FIRST, PH_SECOND
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] instr_address;
      logic [7:0]  opcode_byte;
      logic [5:0]  operation;
      logic [3:0]  address_mode;
      logic [1:0]  operand_count;
      logic [7:0]  operand_low;
      logic [7:0]  operand_high;
      logic [15:0] branch_target;
   } rsp_type;

   typedef struct packed {
      logic [15:0] address;
      logic [7:0]  opcode;
      logic [7:0]  operand_low;
      logic [7:0]  operand_high;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   typedef struct packed {
      op_type   oper;
      mode_type mode;
   } decode_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CC_GROUP0 = 2'd0;
   localparam logic [1:0] CC_GROUP1 = 2'd1;
   localparam logic [1:0] CC_GROUP2 = 2'd2;

   localparam logic [2:0] BBB_IMM  = 3'd0;
   localparam logic [2:0] BBB_ZP   = 3'd1;
   localparam logic [2:0] BBB_ACC  = 3'd2;
   localparam logic [2:0] BBB_ABS  = 3'd3;
   localparam logic [2:0] BBB_ZPX  = 3'd5;
   localparam logic [2:0] BBB_ABX  = 3'd7;
   localparam logic [2:0] AAA_STX  = 3'd4;
   localparam logic [2:0] AAA_LDX  = 3'd5;
   localparam logic [4:0] BRANCH_PATTERN = 5'h10;

   localparam logic [15:0] VALID_ROWS [0:15] = '{
      16'h6763, 16'h6363, 16'h7773, 16'h6363, 16'h7763, 16'h6363, 16'h7763, 16'h6363,
      16'h7572, 16'h2773, 16'h7777, 16'h7773, 16'h7773, 16'h6363, 16'h7773, 16'h6363
   };

   localparam mode_type G1_MODE [0:7] = '{
      MODE_IZX, MODE_ZP, MODE_IMM, MODE_ABS, MODE_IZY, MODE_ZPX, MODE_ABY, MODE_ABX
   };
   localparam op_type G1_OP [0:7] = '{
      OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_STA, OP_LDA, OP_CMP, OP_SBC
   };
   localparam op_type G2_OP [0:7] = '{
      OP_ASL, OP_ROL, OP_LSR, OP_ROR, OP_STX, OP_LDX, OP_DEC, OP_INC
   };
   localparam op_type G0_OP [0:7] = '{
      OP_ADC, OP_BIT, OP_JMP, OP_JMPI, OP_STY, OP_LDY, OP_CPY, OP_CPX
   };

   function automatic logic opcode_valid(input logic [7:0] opc);
      logic [15:0] row;
      row = VALID_ROWS[opc[7:4]];
      return row[opc[3:0]];
   endfunction

   function automatic decode_type decode(input logic [7:0] opc);
      logic [1:0] cc;
      logic [2:0] aaa;
      logic [2:0] bbb;
      logic       xy;
      decode_type d;
      cc  = opc[1:0];
      aaa = opc[7:5];
      bbb = opc[4:2];
      xy  = (aaa == AAA_STX) || (aaa == AAA_LDX);
      d.oper = OP_ADC;
      d.mode = MODE_IMP;
      case (cc)
         CC_GROUP1: begin
            d.mode = G1_MODE[bbb];
            d.oper = G1_OP[aaa];
         end
         CC_GROUP2: begin
            d.oper = G2_OP[aaa];
            case (bbb)
               BBB_IMM: d.mode = MODE_IMM;
               BBB_ZP:  d.mode = MODE_ZP;
               BBB_ACC: d.mode = MODE_ACC;
               BBB_ABS: d.mode = MODE_ABS;
               BBB_ZPX: d.mode = xy ? MODE_ZPY : MODE_ZPX;
               BBB_ABX: d.mode = xy ? MODE_ABY : MODE_ABX;
               default: ;
            endcase
         end
         CC_GROUP0: begin
            d.oper = G0_OP[aaa];
            case (bbb)
               BBB_IMM: d.mode = MODE_IMM;
               BBB_ZP:  d.mode = MODE_ZP;
               BBB_ABS: d.mode = MODE_ABS;
               BBB_ZPX: d.mode = MODE_ZPX;
               BBB_ABX: d.mode = MODE_ABX;
               default: ;
            endcase
         end
         default: ;
      endcase
      if (opc[4:0] == BRANCH_PATTERN) begin
         d.oper = op_type'(6'(OP_BPL) + 6'(aaa));
         d.mode = MODE_REL;
      end
      unique case (opc)
         8'h08: begin d.oper = OP_PHP; d.mode = MODE_IMP; end
         8'h28: begin d.oper = OP_PLP; d.mode = MODE_IMP; end
         8'h48: begin d.oper = OP_PHA; d.mode = MODE_IMP; end
         8'h68: begin d.oper = OP_PLA; d.mode = MODE_IMP; end
         8'h88: begin d.oper = OP_DEY; d.mode = MODE_IMP; end
         8'hA8: begin d.oper = OP_TAY; d.mode = MODE_IMP; end
         8'hC8: begin d.oper = OP_INY; d.mode = MODE_IMP; end
         8'hE8: begin d.oper = OP_INX; d.mode = MODE_IMP; end
         8'h18: begin d.oper = OP_CLC; d.mode = MODE_IMP; end
         8'h38: begin d.oper = OP_SEC; d.mode = MODE_IMP; end
         8'h58: begin d.oper = OP_CLI; d.mode = MODE_IMP; end
         8'h78: begin d.oper = OP_SEI; d.mode = MODE_IMP; end
         8'h98: begin d.oper = OP_TYA; d.mode = MODE_IMP; end
         8'hB8: begin d.oper = OP_CLV; d.mode = MODE_IMP; end
         8'hD8: begin d.oper = OP_CLD; d.mode = MODE_IMP; end
         8'hF8: begin d.oper = OP_SED; d.mode = MODE_IMP; end
         8'h8A: begin d.oper = OP_TXA; d.mode = MODE_IMP; end
         8'h9A: begin d.oper = OP_TXS; d.mode = MODE_IMP; end
         8'hAA: begin d.oper = OP_TAX; d.mode = MODE_IMP; end
         8'hBA: begin d.oper = OP_TSX; d.mode = MODE_IMP; end
         8'hCA: begin d.oper = OP_DEX; d.mode = MODE_IMP; end
         8'hEA: begin d.oper = OP_NOP; d.mode = MODE_IMP; end
         8'h60: begin d.oper = OP_RTS; d.mode = MODE_IMP; end
         8'h00: begin d.oper = OP_BRK; d.mode = MODE_IMP; end
         8'h40: begin d.oper = OP_RTI; d.mode = MODE_IMP; end
         8'h20: begin d.oper = OP_JSR; d.mode = MODE_ABS; end
         default: ;
      endcase
      return d;
   endfunction

   function automatic logic [1:0] mode_len(input mode_type m);
      logic [1:0] len;
      unique case (m) inside
         MODE_IMM, MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL, MODE_IZX, MODE_IZY:
            len = 2'd1;
         MODE_ABS, MODE_ABX, MODE_ABY:
            len = 2'd2;
         default:
            len = 2'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/core/m6502dis_front.sv =====
// Front end: takes image bytes, tracks opcode/operand phase and image position,
// and pushes assembled instructions to the queue. Depends on m6502dis_pkg.
`timescale 1ns / 1ps

module m6502dis_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  m6502dis_pkg::req_type req_data,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data,
   output m6502dis_pkg::push_type push_out
);
   import m6502dis_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] position_ff, position_in;
   logic [15:0] start_address_ff;
   logic [7:0]  held_opcode_ff, held_opcode_in;
   logic [7:0]  held_operand_ff, held_operand_in;
   logic [15:0] held_address_ff, held_address_in;
   logic        held_two_ff, held_two_in;
   logic [15:0] opcode_address;
   logic [1:0]  opcode_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_OPCODE;
         position_ff      <= '0;
         start_address_ff <= '0;
         held_two_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         held_two_ff <= held_two_in;
         if (csr_write_enable) begin
            start_address_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_opcode_ff  <= held_opcode_in;
      held_operand_ff <= held_operand_in;
      held_address_ff <= held_address_in;
   end

   assign opcode_address = start_address_ff + position_ff;
   assign opcode_len     = mode_len(decode(req_data.data_byte).mode);

   always_comb begin
      phase_in        = phase_ff;
      position_in     = position_ff;
      held_opcode_in  = held_opcode_ff;
      held_operand_in = held_operand_ff;
      held_address_in = held_address_ff;
      held_two_in     = held_two_ff;
      push_out.push               = 1'b0;
      push_out.entry.address      = held_address_ff;
      push_out.entry.opcode       = held_opcode_ff;
      push_out.entry.operand_low  = req_data.data_byte;
      push_out.entry.operand_high = '0;
      if (accept) begin
         position_in = position_ff + 16'd1;
         unique case (phase_ff)
            PH_FIRST: begin
               if (held_two_ff) begin
                  held_operand_in = req_data.data_byte;
                  phase_in        = PH_SECOND;
               end else begin
                  push_out.push = 1'b1;
                  phase_in      = PH_OPCODE;
               end
            end
            PH_SECOND: begin
               push_out.push               = 1'b1;
               push_out.entry.operand_low  = held_operand_ff;
               push_out.entry.operand_high = req_data.data_byte;
               phase_in                    = PH_OPCODE;
            end
            default: begin
               phase_in = PH_OPCODE;
               if (opcode_valid(req_data.data_byte)) begin
                  held_opcode_in  = req_data.data_byte;
                  held_address_in = opcode_address;
                  if (opcode_len == 2'd0) begin
                     push_out.push              = 1'b1;
                     push_out.entry.address     = opcode_address;
                     push_out.entry.opcode      = req_data.data_byte;
                     push_out.entry.operand_low = '0;
                  end else begin
                     phase_in    = PH_FIRST;
                     held_two_in = (opcode_len == 2'd2);
                  end
               end
            end
         endcase
         // drop any unfinished instruction at the image end
         if (req_data.last_byte) begin
            position_in = '0;
            phase_in    = PH_OPCODE;
         end
      end
   end

endmodule

// ===== rtl/core/m6502dis_queue.sv =====
// Short instruction queue between front and back ends.
// Depends on m6502dis_pkg for the entry type and depth.
`timescale 1ns / 1ps

module m6502dis_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  m6502dis_pkg::push_type   push_in,
   input  logic                     pop,
   output m6502dis_pkg::entry_type  head,
   output logic                     empty,
   output logic                     full
);
   import m6502dis_pkg::*;

   entry_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic                     do_push;
   logic                     do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_push = push_in.push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

endmodule

// ===== rtl/core/m6502dis_back.sv =====
// Back end: decodes the queued instruction, forms the branch target and
// holds the record in the output register. Depends on m6502dis_pkg.
`timescale 1ns / 1ps

module m6502dis_back (
   input  logic                    clock,
   input  logic                    reset,
   input  m6502dis_pkg::entry_type head,
   input  logic                    empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output m6502dis_pkg::rsp_type   rsp_data
);
   import m6502dis_pkg::*;

   logic       out_valid_ff;
   rsp_type    out_data_ff, out_data_in;
   decode_type dec;

   assign dec = decode(head.opcode);
   assign pop = !empty && (!out_valid_ff || !rsp_stall);

   always_comb begin
      out_data_in.instr_address = head.address;
      out_data_in.opcode_byte   = head.opcode;
      out_data_in.operation     = 6'(dec.oper);
      out_data_in.address_mode  = 4'(dec.mode);
      out_data_in.operand_count = mode_len(dec.mode);
      out_data_in.operand_low   = head.operand_low;
      out_data_in.operand_high  = head.operand_high;
      out_data_in.branch_target = '0;
      if (dec.mode == MODE_REL) begin
         out_data_in.branch_target = head.address + 16'd2
                                   + {{8{head.operand_low[7]}}, head.operand_low};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pop) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/core/mos6502_stream_disassembler_top.sv =====
// A completed record is written into the queue, then into the output register.
// Throughput: one image byte per cycle while the queue is not full, one record per cycle
//   while rsp_stall is low; the front end and a 4-entry queue to the decode/output stage set this.
// req_stall rises only when the queue is full; rsp_stall does not reach it directly.
// Reset (synchronous): clears phase, image position, start address, queue and output.
// No clearing pass; the block takes bytes on the first cycle after reset.
`timescale 1ns / 1ps

module mos6502_stream_disassembler_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  m6502dis_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output m6502dis_pkg::rsp_type rsp_data,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data
);
   import m6502dis_pkg::*;

   push_type  push;
   entry_type head;
   logic      empty;
   logic      full;
   logic      pop;
   logic      accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   m6502dis_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_out         (push)
   );

   m6502dis_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .head    (head),
      .empty   (empty),
      .full    (full)
   );

   m6502dis_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/m6502dis_checker.sv =====
// Port-level checks on the disassembler result channel, bound to the top level.
// Depends on m6502dis_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "mos6502_stream_disassembler_top_defines.svh"

module m6502dis_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input m6502dis_pkg::rsp_type rsp_data
);
   import m6502dis_pkg::*;

   `M6502DIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `M6502DIS_ASSERT_NOW(a_no_operands, clock, reset, rsp_valid && (rsp_data.operand_count == 2'd0), (rsp_data.operand_low == 8'd0) && (rsp_data.operand_high == 8'd0))
   `M6502DIS_ASSERT_NOW(a_high_absent, clock, reset, rsp_valid && (rsp_data.operand_count != 2'd2), rsp_data.operand_high == 8'd0)
   `M6502DIS_ASSERT_NOW(a_target_rel, clock, reset, rsp_valid && (rsp_data.address_mode != 4'(MODE_REL)), rsp_data.branch_target == 16'd0)

endmodule

bind mos6502_stream_disassembler_top m6502dis_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/mos6502_stream_disassembler_top_test.sv =====
// Self-checking bench for the 6502 stream disassembler: a scoreboard class predicts one
// record per completed instruction; plain tasks feed image bytes, an always block takes records.
// Depends on m6502dis_pkg and mos6502_stream_disassembler_top.
`timescale 1ns / 1ps

import m6502dis_pkg::*;

class disasm_scoreboard;

   rsp_type     expected_records [$];
   int unsigned mismatches = 0;

   logic [15:0] start_address  = '0;
   logic [15:0] held_address   = '0;
   logic [15:0] image_position = '0;
   logic [7:0]  held_opcode    = '0;
   logic [7:0]  held_operand   = '0;
   phase_type   phase          = PH_OPCODE;

   op_type   alu_ops [8]    = '{OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_STA, OP_LDA, OP_CMP, OP_SBC};
   op_type   rmw_ops [8]    = '{OP_ASL, OP_ROL, OP_LSR, OP_ROR, OP_STX, OP_LDX, OP_DEC, OP_INC};
   op_type   ctl_ops [8]    = '{OP_ADC, OP_BIT, OP_JMP, OP_JMPI, OP_STY, OP_LDY, OP_CPY, OP_CPX};
   op_type   branch_ops [8] = '{OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ};
   mode_type alu_modes [8]  = '{MODE_IZX, MODE_ZP, MODE_IMM, MODE_ABS,
                                MODE_IZY, MODE_ZPX, MODE_ABY, MODE_ABX};

   function void set_start(input logic [15:0] value);
      start_address = value;
   endfunction

   function int unsigned pending();
      return expected_records.size();
   endfunction

   function bit is_documented(input logic [7:0] opc);
      logic [15:0] row;
      case (opc[7:4])
         4'h0: row = 16'h6763;
         4'h1: row = 16'h6363;
         4'h2: row = 16'h7773;
         4'h3: row = 16'h6363;
         4'h4: row = 16'h7763;
         4'h5: row = 16'h6363;
         4'h6: row = 16'h7763;
         4'h7: row = 16'h6363;
         4'h8: row = 16'h7572;
         4'h9: row = 16'h2773;
         4'hA: row = 16'h7777;
         4'hB: row = 16'h7773;
         4'hC: row = 16'h7773;
         4'hD: row = 16'h6363;
         4'hE: row = 16'h7773;
         default: row = 16'h6363;
      endcase
      return row[opc[3:0]];
   endfunction

   function void decode_opcode(input logic [7:0] opc, output op_type oper,
                               output mode_type mode);
      logic [2:0] aaa;
      logic [2:0] bbb;
      logic       index_y;
      aaa     = opc[7:5];
      bbb     = opc[4:2];
      index_y = (aaa == AAA_STX) || (aaa == AAA_LDX);
      oper    = OP_ADC;
      mode    = MODE_IMP;
      case (opc[1:0])
         CC_GROUP1: begin
            oper = alu_ops[aaa];
            mode = alu_modes[bbb];
         end
         CC_GROUP2: begin
            oper = rmw_ops[aaa];
            case (bbb)
               BBB_IMM: mode = MODE_IMM;
               BBB_ZP:  mode = MODE_ZP;
               BBB_ACC: mode = MODE_ACC;
               BBB_ABS: mode = MODE_ABS;
               BBB_ZPX: mode = index_y ? MODE_ZPY : MODE_ZPX;
               BBB_ABX: mode = index_y ? MODE_ABY : MODE_ABX;
               default: ;
            endcase
         end
         CC_GROUP0: begin
            oper = ctl_ops[aaa];
            case (bbb)
               BBB_IMM: mode = MODE_IMM;
               BBB_ZP:  mode = MODE_ZP;
               BBB_ABS: mode = MODE_ABS;
               BBB_ZPX: mode = MODE_ZPX;
               BBB_ABX: mode = MODE_ABX;
               default: ;
            endcase
         end
         default: ;
      endcase
      if (opc[4:0] == BRANCH_PATTERN) begin
         oper = branch_ops[aaa];
         mode = MODE_REL;
      end
      case (opc)
         8'h08: oper = OP_PHP;
         8'h28: oper = OP_PLP;
         8'h48: oper = OP_PHA;
         8'h68: oper = OP_PLA;
         8'h88: oper = OP_DEY;
         8'hA8: oper = OP_TAY;
         8'hC8: oper = OP_INY;
         8'hE8: oper = OP_INX;
         8'h18: oper = OP_CLC;
         8'h38: oper = OP_SEC;
         8'h58: oper = OP_CLI;
         8'h78: oper = OP_SEI;
         8'h98: oper = OP_TYA;
         8'hB8: oper = OP_CLV;
         8'hD8: oper = OP_CLD;
         8'hF8: oper = OP_SED;
         8'h8A: oper = OP_TXA;
         8'h9A: oper = OP_TXS;
         8'hAA: oper = OP_TAX;
         8'hBA: oper = OP_TSX;
         8'hCA: oper = OP_DEX;
         8'hEA: oper = OP_NOP;
         8'h60: oper = OP_RTS;
         8'h00: oper = OP_BRK;
         8'h40: oper = OP_RTI;
         default: ;
      endcase
      case (opc)
         8'h08, 8'h28, 8'h48, 8'h68, 8'h88, 8'hA8, 8'hC8, 8'hE8,
         8'h18, 8'h38, 8'h58, 8'h78, 8'h98, 8'hB8, 8'hD8, 8'hF8,
         8'h8A, 8'h9A, 8'hAA, 8'hBA, 8'hCA, 8'hEA, 8'h60, 8'h00, 8'h40:
            mode = MODE_IMP;
         8'h20: begin
            oper = OP_JSR;
            mode = MODE_ABS;
         end
         default: ;
      endcase
   endfunction

   function logic [1:0] operand_bytes(input mode_type mode);
      case (mode)
         MODE_ABS, MODE_ABX, MODE_ABY: return 2'd2;
         MODE_IMP, MODE_ACC:           return 2'd0;
         default:                      return 2'd1;
      endcase
   endfunction

   function int unsigned operand_total(input logic [7:0] opc);
      op_type   oper;
      mode_type mode;
      decode_opcode(opc, oper, mode);
      return operand_bytes(mode);
   endfunction

   function rsp_type make_record(input logic [7:0] lo, input logic [7:0] hi);
      rsp_type  rec;
      op_type   oper;
      mode_type mode;
      decode_opcode(held_opcode, oper, mode);
      rec.instr_address = held_address;
      rec.opcode_byte   = held_opcode;
      rec.operation     = oper;
      rec.address_mode  = mode;
      rec.operand_count = operand_bytes(mode);
      rec.operand_low   = lo;
      rec.operand_high  = hi;
      rec.branch_target = (mode == MODE_REL) ? held_address + 16'd2 + {{8{lo[7]}}, lo} : '0;
      return rec;
   endfunction

   function void note_request(input req_type request);
      op_type   oper;
      mode_type mode;
      if (phase == PH_FIRST || phase == PH_SECOND) begin
         decode_opcode(held_opcode, oper, mode);
         if (phase == PH_FIRST && operand_bytes(mode) == 2'd2) begin
            held_operand = request.data_byte;
            phase        = PH_SECOND;
         end else begin
            if (phase == PH_FIRST)
               expected_records.push_back(make_record(request.data_byte, 8'h00));
            else
               expected_records.push_back(make_record(held_operand, request.data_byte));
            phase = PH_OPCODE;
         end
      end else begin
         phase = PH_OPCODE;
         if (is_documented(request.data_byte)) begin
            held_opcode  = request.data_byte;
            held_address = start_address + image_position;
            decode_opcode(held_opcode, oper, mode);
            if (operand_bytes(mode) == 2'd0)
               expected_records.push_back(make_record(8'h00, 8'h00));
            else
               phase = PH_FIRST;
         end
      end
      image_position = image_position + 16'd1;
      if (request.last_byte) begin
         image_position = '0;
         phase          = PH_OPCODE;
      end
   endfunction

   function void compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %h got %h", $time, field, want, got);
      end
   endfunction

   function void check_result(input rsp_type got);
      rsp_type want;
      if (expected_records.size() == 0) begin
         mismatches++;
         $display("%0t: record expected none got %h", $time, got);
         return;
      end
      want = expected_records.pop_front();
      compare_field("instr_address", want.instr_address, got.instr_address);
      compare_field("opcode_byte", 16'(want.opcode_byte), 16'(got.opcode_byte));
      compare_field("operation", 16'(want.operation), 16'(got.operation));
      compare_field("address_mode", 16'(want.address_mode), 16'(got.address_mode));
      compare_field("operand_count", 16'(want.operand_count), 16'(got.operand_count));
      compare_field("operand_low", 16'(want.operand_low), 16'(got.operand_low));
      compare_field("operand_high", 16'(want.operand_high), 16'(got.operand_high));
      compare_field("branch_target", want.branch_target, got.branch_target);
   endfunction

endclass

module mos6502_stream_disassembler_top_test;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_BYTES   = 370;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   req_type     req_data         = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data   = '0;

   int unsigned      idle_pct    = 18;
   int unsigned      cycle_count = 0;
   disasm_scoreboard sb          = new;
   logic [15:0]      phase_starts [5];

   req_type opening [21] = '{
      {8'hA9, 1'b0}, {8'h00, 1'b0},
      {8'h8D, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
      {8'h10, 1'b0}, {8'h80, 1'b0},
      {8'hD0, 1'b0}, {8'h7F, 1'b0},
      {8'hBE, 1'b0}, {8'h34, 1'b0}, {8'h12, 1'b0},
      {8'h6C, 1'b0}, {8'hFF, 1'b0}, {8'h00, 1'b0},
      {8'h20, 1'b0}, {8'h00, 1'b0}, {8'hC0, 1'b0},
      {8'h0A, 1'b0}, {8'hFF, 1'b0}, {8'hEA, 1'b1}
   };

   mos6502_stream_disassembler_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic ends_image);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {value, ends_image};
      do @(posedge clock); while (req_stall);
      sb.note_request(req_data);
   endtask

   // hold the sender until every record is out, then let the queue settle
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      sb.set_start(value);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_program(input int unsigned budget);
      int unsigned sent;
      int unsigned length;
      logic [7:0]  opc;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 15) begin
            send_byte(8'($urandom_range(255)), $urandom_range(99) < 5);
            sent += 1;
         end else begin
            do opc = 8'($urandom_range(255)); while (!sb.is_documented(opc));
            length = sb.operand_total(opc);
            send_byte(opc, $urandom_range(99) < 2);
            repeat (length) send_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
            sent += length + 1;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      write_start(16'hFFFE);
      foreach (opening[i])
         send_byte(opening[i].data_byte, opening[i].last_byte);

      // leave a JMP open across a register write, then cut off an LDA abs
      send_byte(8'h4C, 1'b0);
      send_byte(8'h10, 1'b0);
      drain_and_settle();
      write_start(16'h8000);
      send_byte(8'hC0, 1'b0);
      send_byte(8'hAD, 1'b0);
      send_byte(8'h34, 1'b1);

      phase_starts[0] = 16'($urandom);
      phase_starts[1] = 16'hFFFF;
      phase_starts[2] = 16'h0000;
      phase_starts[3] = 16'hC000;
      phase_starts[4] = 16'h8000;
      foreach (phase_starts[i]) begin
         drain_and_settle();
         write_start(phase_starts[i]);
         idle_pct = (i == 2) ? 0 : 18;
         send_random_program(PHASE_BYTES);
      end

      drain_and_settle();
      if (sb.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
